FILE: src/assert_macros.svh
// Assertion macros used by the checker file of the circular list block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define CLC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that is also checked across reset.
`define CLC_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/clc_pkg.sv
// Types, codes and defaults shared by the circular list modules.
package clc_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    OP_INS_TAIL  = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_FIRST     = 3'd2,
    OP_NEXT      = 3'd3,
    OP_REMOVE    = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NOCUR = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] data_out;
    logic [4:0]  element_count;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_ALLOC,
    S_INS_LINK,
    S_WALK_RD,
    S_WALK_STEP,
    S_WALK_DONE,
    S_RM_RD,
    S_RM_UNLINK
  } state_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_REPORT,
    ACT_CAPTURE,
    ACT_INS_READ,
    ACT_INS_ALLOC,
    ACT_INS_LINK,
    ACT_WALK_READ,
    ACT_WALK_STEP,
    ACT_WALK_DONE,
    ACT_RM_READ,
    ACT_RM_UNLINK
  } dp_act_t;

  typedef struct packed {
    dp_act_t    act;
    logic [1:0] err_status;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic cur_valid;
    logic rm_allowed;
  } dp_flags_t;

endpackage

FILE: src/clc_ctrl.sv
// Controller state machine that sequences each list operation.
module clc_ctrl import clc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] in_op,
  input  dp_flags_t  flags,
  output logic       busy,
  output dp_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd.act        = ACT_NONE;
    cmd.err_status = ST_OK;
    busy           = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          // Failing operations report at once and never leave idle.
          unique case (in_op)
            OP_INS_TAIL, OP_INS_FRONT: begin
              if (flags.full) begin
                cmd.act        = ACT_REPORT;
                cmd.err_status = ST_FULL;
              end else begin
                cmd.act   = ACT_CAPTURE;
                state_nxt = S_INS_RD;
              end
            end
            OP_FIRST: begin
              if (flags.empty) begin
                cmd.act        = ACT_REPORT;
                cmd.err_status = ST_EMPTY;
              end else begin
                cmd.act   = ACT_CAPTURE;
                state_nxt = S_WALK_RD;
              end
            end
            OP_NEXT: begin
              if (flags.empty) begin
                cmd.act        = ACT_REPORT;
                cmd.err_status = ST_EMPTY;
              end else if (!flags.cur_valid) begin
                cmd.act        = ACT_REPORT;
                cmd.err_status = ST_NOCUR;
              end else begin
                cmd.act   = ACT_CAPTURE;
                state_nxt = S_WALK_RD;
              end
            end
            OP_REMOVE: begin
              if (flags.empty) begin
                cmd.act        = ACT_REPORT;
                cmd.err_status = ST_EMPTY;
              end else if (!flags.cur_valid || !flags.rm_allowed) begin
                cmd.act        = ACT_REPORT;
                cmd.err_status = ST_NOCUR;
              end else begin
                cmd.act   = ACT_CAPTURE;
                state_nxt = S_RM_RD;
              end
            end
            default: begin
              cmd.act        = ACT_REPORT;
              cmd.err_status = ST_OK;
            end
          endcase
        end
      end
      S_INS_RD: begin
        cmd.act   = ACT_INS_READ;
        state_nxt = S_INS_ALLOC;
      end
      S_INS_ALLOC: begin
        cmd.act   = ACT_INS_ALLOC;
        state_nxt = flags.empty ? S_IDLE : S_INS_LINK;
      end
      S_INS_LINK: begin
        cmd.act   = ACT_INS_LINK;
        state_nxt = S_IDLE;
      end
      S_WALK_RD: begin
        cmd.act   = ACT_WALK_READ;
        state_nxt = S_WALK_STEP;
      end
      S_WALK_STEP: begin
        cmd.act   = ACT_WALK_STEP;
        state_nxt = S_WALK_DONE;
      end
      S_WALK_DONE: begin
        cmd.act   = ACT_WALK_DONE;
        state_nxt = S_IDLE;
      end
      S_RM_RD: begin
        cmd.act   = ACT_RM_READ;
        state_nxt = S_RM_UNLINK;
      end
      S_RM_UNLINK: begin
        cmd.act   = ACT_RM_UNLINK;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/clc_dpath.sv
// Datapath with the node pool memories, list pointers and result register.
module clc_dpath import clc_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_flags_t flags,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] val_mem  [DEPTH];
  logic [IDX_W-1:0]      link_mem [DEPTH];
  logic [IDX_W-1:0]      free_mem [DEPTH];

  logic [2:0]            op_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [IDX_W-1:0]      new_r;
  logic [IDX_W-1:0]      tail_r;
  logic                  nonempty_r;
  logic [IDX_W-1:0]      cursor_r;
  logic [IDX_W-1:0]      prev_r;
  logic                  cur_valid_r;
  logic                  rm_ok_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic [CNT_W-1:0]      fresh_r;
  logic [CNT_W-1:0]      fsp_r;
  logic [CNT_W-1:0]      fsp_dec;
  logic [IDX_W-1:0]      link_rd_r;
  logic [DATA_WIDTH-1:0] val_rd_r;
  logic [IDX_W-1:0]      free_rd_r;
  logic                  res_valid_r;
  out_item_t             res_r;
  out_item_t             res_nxt;
  logic                  fin;

  logic [IDX_W-1:0]      walk_base;
  logic [IDX_W-1:0]      new_slot;
  logic                  last;
  logic                  link_re, link_we;
  logic [IDX_W-1:0]      link_ra, link_wa, link_wd;
  logic                  val_re, val_we;
  logic [IDX_W-1:0]      val_ra;
  logic                  free_re, free_we;

  assign flags.empty      = !nonempty_r;
  assign flags.full       = (count_r == CNT_W'(DEPTH));
  assign flags.cur_valid  = cur_valid_r;
  assign flags.rm_allowed = rm_ok_r;

  assign walk_base = (op_r == OP_FIRST) ? tail_r : cursor_r;
  // Recycled slots are used first; untouched slots are handed out in order.
  assign new_slot  = (fsp_r != '0) ? free_rd_r : fresh_r[IDX_W-1:0];
  assign last      = (link_rd_r == cursor_r);
  assign fsp_dec   = fsp_r - 1'b1;

  always_comb begin
    link_re   = 1'b0;
    link_ra   = tail_r;
    link_we   = 1'b0;
    link_wa   = tail_r;
    link_wd   = new_r;
    val_re    = 1'b0;
    val_ra    = cursor_r;
    val_we    = 1'b0;
    free_re   = 1'b0;
    free_we   = 1'b0;
    count_nxt = count_r;
    fin       = 1'b0;
    unique case (cmd.act)
      ACT_REPORT: begin
        fin = 1'b1;
      end
      ACT_INS_READ: begin
        link_re = 1'b1;
        link_ra = tail_r;
        free_re = (fsp_r != '0);
      end
      ACT_INS_ALLOC: begin
        link_we   = 1'b1;
        link_wa   = new_slot;
        link_wd   = nonempty_r ? link_rd_r : new_slot;
        val_we    = 1'b1;
        count_nxt = count_r + 1'b1;
        fin       = !nonempty_r;
      end
      ACT_INS_LINK: begin
        link_we = 1'b1;
        link_wa = tail_r;
        link_wd = new_r;
        fin     = 1'b1;
      end
      ACT_WALK_READ: begin
        link_re = 1'b1;
        link_ra = walk_base;
      end
      ACT_WALK_STEP: begin
        val_re = 1'b1;
        val_ra = link_rd_r;
      end
      ACT_WALK_DONE: begin
        fin = 1'b1;
      end
      ACT_RM_READ: begin
        link_re = 1'b1;
        link_ra = cursor_r;
        val_re  = 1'b1;
        val_ra  = cursor_r;
      end
      ACT_RM_UNLINK: begin
        link_we   = !last;
        link_wa   = prev_r;
        link_wd   = link_rd_r;
        free_we   = 1'b1;
        count_nxt = last ? '0 : count_r - 1'b1;
        fin       = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_nxt.ok            = (cmd.act != ACT_REPORT);
    res_nxt.data_out      = '0;
    if (cmd.act == ACT_WALK_DONE || cmd.act == ACT_RM_UNLINK) begin
      res_nxt.data_out = 32'(64'(val_rd_r));
    end
    res_nxt.element_count = 5'(count_nxt);
    res_nxt.status        = (cmd.act == ACT_REPORT) ? cmd.err_status : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (link_re) link_rd_r <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[new_slot] <= data_r;
    if (val_re) val_rd_r <= val_mem[val_ra];
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[fsp_r[IDX_W-1:0]] <= cursor_r;
    if (free_re) free_rd_r <= free_mem[fsp_dec[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.act == ACT_CAPTURE) begin
      op_r   <= in_item.operation;
      data_r <= DATA_WIDTH'(64'(in_item.data_in));
    end
    if (cmd.act == ACT_INS_ALLOC) begin
      new_r <= new_slot;
    end
    if (fin) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r      <= '0;
      nonempty_r  <= 1'b0;
      cursor_r    <= '0;
      prev_r      <= '0;
      cur_valid_r <= 1'b0;
      rm_ok_r     <= 1'b0;
      count_r     <= '0;
      fresh_r     <= '0;
      fsp_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= fin;
      count_r     <= count_nxt;
      unique case (cmd.act)
        ACT_INS_ALLOC: begin
          if (fsp_r != '0) begin
            fsp_r <= fsp_dec;
          end else begin
            fresh_r <= fresh_r + 1'b1;
          end
          if (!nonempty_r) begin
            tail_r     <= new_slot;
            nonempty_r <= 1'b1;
          end
        end
        ACT_INS_LINK: begin
          // A new node linked after the tail becomes the cursor's predecessor if that was the tail.
          if (cur_valid_r && prev_r == tail_r) begin
            prev_r <= new_r;
          end
          if (op_r == OP_INS_TAIL) begin
            tail_r <= new_r;
          end
        end
        ACT_WALK_STEP: begin
          prev_r   <= walk_base;
          cursor_r <= link_rd_r;
        end
        ACT_WALK_DONE: begin
          cur_valid_r <= 1'b1;
          rm_ok_r     <= 1'b1;
        end
        ACT_RM_UNLINK: begin
          fsp_r   <= fsp_r + 1'b1;
          rm_ok_r <= 1'b0;
          if (last) begin
            tail_r      <= '0;
            nonempty_r  <= 1'b0;
            cursor_r    <= '0;
            prev_r      <= '0;
            cur_valid_r <= 1'b0;
          end else begin
            if (cursor_r == tail_r) begin
              tail_r <= prev_r;
            end
            cursor_r <= prev_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = res_valid_r;
  assign out_item  = res_r;

endmodule

FILE: src/circular_list_with_cursor.sv
// Top level of the circular singly linked list with a cursor.
// A failing beat shows its result in the cycle after it is accepted. Inserts step through
// insert read, allocate and (unless the list was empty) link states; first and next through
// walk read, step and done; remove through remove read and unlink. A new beat is taken in
// the cycle the last result is strobed; the states follow the registered single-port reads
// of the link and value memories. Results are strobed for one cycle; the receiver cannot stall.
// Reset is synchronous and active low: the list comes up empty, no clearing pass is run.
module circular_list_with_cursor import clc_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  // The controller judges each beat against the list flags when it is
  // offered. Errors are answered straight from idle; good beats are
  // captured and walked through the short sequence of states for their operation.
  dp_cmd_t   cmd;
  dp_flags_t flags;

  clc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_item.operation),
    .flags (flags),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds the value and link memories, a free-slot stack that
  // recycles removed entries, the tail, cursor and predecessor pointers,
  // and the registered result beat.
  clc_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .flags     (flags),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: src/clc_checker.sv
// Port-level checker for the circular list block, bound to its top level.
`include "assert_macros.svh"

module clc_checker import clc_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  `CLC_ASSERT(a_accept_answered, start && !busy |=> out_valid || busy, "Accepted beat left neither busy nor a result")
  `CLC_ASSERT(a_ok_status, out_valid && out_item.ok |-> out_item.status == ST_OK, "Successful result with error status")
  `CLC_ASSERT(a_fail_no_data, out_valid && !out_item.ok |-> out_item.data_out == '0, "Failed result carries data")
  `CLC_ASSERT(a_count_range, out_valid |-> out_item.element_count <= DEPTH, "Element count above pool depth")
  `CLC_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid && !busy, "Block not quiet after reset")

endmodule

bind circular_list_with_cursor clc_checker #(.DEPTH(DEPTH)) u_clc_checker (.*);
